// ----- hdl/rbol_pkg.sv -----
`timescale 1ns / 1ps
package rbol_pkg;
  localparam int MapRows = 256;
  localparam int Capacity = 1024;
  localparam int IdxW = $clog2(Capacity) + 1;
  localparam int RowW = $clog2(MapRows);
  localparam int CostW = 24;
  localparam logic [IdxW-1:0] Nil = IdxW'(Capacity);

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StDropped = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic [31:0] pos;
    logic [CostW-1:0] f;
    logic [CostW-1:0] g;
    logic [15:0] rad;
  } entry_t;
endpackage

// ----- hdl/row_bucketed_open_list_unit.sv -----
`timescale 1ns / 1ps
// channel  | signals                                   | direction
// cfg      | cfg_we_i, cfg_wdata_i                     | in
// input    | in_valid_i, in_stall_o, command_i..radius_i | in
// output   | out_valid_o, out_stall_i, out_*_o, status_o | out
// one word at a time; an add walks the chain of its row entry by entry, a pop visits
// each row in use and reads the head entry of each non-empty row; the entry, link and
// row head memories each have one read and one write port. after reset and after each
// cfg write a clearing pass rebuilds the free chain and row heads; no word is
// taken meanwhile. a finished word waits in the output register while out_stall_i is high.
module row_bucketed_open_list_unit import rbol_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  parent_row_i,
  input  logic [7:0]  parent_col_i,
  input  logic [23:0] total_cost_i,
  input  logic [23:0] path_cost_i,
  input  logic [15:0] radius_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_row_o,
  output logic [7:0]  out_col_o,
  output logic [7:0]  out_parent_row_o,
  output logic [7:0]  out_parent_col_o,
  output logic [23:0] out_total_cost_o,
  output logic [23:0] out_path_cost_o,
  output logic [15:0] out_radius_o,
  output logic [1:0]  status_o,
  output logic [10:0] entry_count_o
);
  localparam int AW = $clog2(Capacity);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_HEAD, S_A_RD, S_A_CHK, S_A_ALLOC, S_A_LINK,
    S_P_RD, S_P_HD, S_P_CMP, S_P_RM, S_DONE
  } state_e;

  state_e state_q;
  logic [IdxW-1:0] free_q, cnt_q;
  logic [8:0] rows_q;
  logic [AW-1:0] clr_q;

  // row head memory
  logic [IdxW-1:0] head_mem_q [MapRows];
  logic [IdxW-1:0] head_rd_q;

  // request
  logic [RowW-1:0] row_q;
  entry_t req_q;
  // walk
  logic [IdxW-1:0] it_q, prev_q, ins_prev_q, ins_at_q, hd_q;
  logic found_q;
  logic [RowW:0] scan_q;
  logic [IdxW-1:0] best_q;
  logic [RowW-1:0] best_row_q;
  logic [CostW-1:0] best_f_q, best_g_q;
  logic [1:0] step_q;
  logic out_valid_q;
  entry_t out_q;
  logic [1:0] status_q;

  // memory ports
  logic e_we, l_we, h_we;
  logic [AW-1:0] e_wa, e_ra, l_wa, l_ra;
  logic [RowW-1:0] h_wa, h_ra;
  entry_t e_wd, e_rd;
  logic [IdxW-1:0] l_wd, l_rd, h_wd;

  rbol_entry_ram u_entry (.clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd),
                          .raddr_i(e_ra), .rdata_o(e_rd));
  rbol_link_ram u_link (.clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd),
                        .raddr_i(l_ra), .rdata_o(l_rd));

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      head_mem_q[h_wa] <= h_wd;
    end
    head_rd_q <= head_mem_q[h_ra];
  end

  logic [8:0] eff_rows;
  always_comb begin
    eff_rows = rows_q;
    if (rows_q == 9'd0) eff_rows = 9'd1;
    if (rows_q > 9'(MapRows)) eff_rows = 9'(MapRows);
  end

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_row_o = out_q.pos[31:24];
  assign out_col_o = out_q.pos[23:16];
  assign out_parent_row_o = out_q.pos[15:8];
  assign out_parent_col_o = out_q.pos[7:0];
  assign out_total_cost_o = out_q.f;
  assign out_path_cost_o = out_q.g;
  assign out_radius_o = out_q.rad;
  assign status_o = status_q;
  assign entry_count_o = 11'(cnt_q);

  // memory control: chain walk needs an entry read and a link read of the same index
  always_comb begin
    e_we = 1'b0; e_wa = it_q[AW-1:0]; e_wd = req_q; e_ra = it_q[AW-1:0];
    l_we = 1'b0; l_wa = it_q[AW-1:0]; l_wd = Nil; l_ra = it_q[AW-1:0];
    h_we = 1'b0; h_wa = row_q; h_wd = it_q; h_ra = row_q;
    case (state_q)
      S_CLEAR: begin
        l_we = 1'b1; l_wa = clr_q; l_wd = IdxW'(clr_q) + IdxW'(1);
        h_we = (clr_q[AW-1:RowW] == '0); h_wa = clr_q[RowW-1:0]; h_wd = Nil;
      end
      S_IDLE: begin
        // head of the incoming row is ready in the first add cycle
        h_ra = row_i;
      end
      S_A_CHK: begin
        // in-place update of the match at the insertion point
        if (e_rd.pos == req_q.pos && req_q.f < e_rd.f &&
            (found_q ? ins_at_q == it_q : e_rd.f >= req_q.f)) begin
          e_we = 1'b1; e_wa = it_q[AW-1:0];
        end else if (e_rd.pos == req_q.pos && req_q.f < e_rd.f) begin
          // unlink the match; prev is never nil here
          l_we = 1'b1; l_wa = prev_q[AW-1:0]; l_wd = l_rd;
          e_we = 1'b1; e_wa = it_q[AW-1:0];
        end
      end
      S_A_ALLOC: begin
        l_ra = free_q[AW-1:0];
        if (step_q == 2'd0) begin
          e_we = 1'b1; e_wa = free_q[AW-1:0];
        end
      end
      S_A_LINK: begin
        l_ra = ins_prev_q[AW-1:0];
        // step 0: read prev next; step 1: write e.next, step 2: write prev.next or head
        if (step_q == 2'd1) begin
          l_we = 1'b1; l_wa = it_q[AW-1:0];
          l_wd = (ins_prev_q == Nil) ? head_rd_q : l_rd;
        end else if (step_q == 2'd2) begin
          if (ins_prev_q != Nil) begin
            l_we = 1'b1; l_wa = ins_prev_q[AW-1:0]; l_wd = it_q;
          end else begin
            h_we = 1'b1;
          end
        end
      end
      S_P_RD: begin
        h_ra = scan_q[RowW-1:0];
      end
      S_P_HD: begin
        e_ra = head_rd_q[AW-1:0];
      end
      S_P_RM: begin
        e_ra = best_q[AW-1:0]; l_ra = best_q[AW-1:0];
        if (step_q == 2'd1) begin
          l_we = 1'b1; l_wa = best_q[AW-1:0]; l_wd = free_q;
          h_we = 1'b1; h_wa = best_row_q; h_wd = l_rd;
        end
      end
      default: ;
    endcase
  end

  logic match, better;
  assign match = e_rd.pos == req_q.pos;
  assign better = req_q.f < e_rd.f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      rows_q <= 9'(MapRows);
      free_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        rows_q <= cfg_wdata_i;
        state_q <= S_CLEAR;
        clr_q <= '0;
        free_q <= '0;
        cnt_q <= '0;
      end else begin
        case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + AW'(1);
            if (clr_q == AW'(Capacity - 1)) state_q <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid_i && !in_stall_o) begin
              row_q <= row_i;
              req_q <= '{pos: {row_i, col_i, parent_row_i, parent_col_i},
                         f: total_cost_i, g: path_cost_i, rad: radius_i};
              out_q <= '0;
              step_q <= '0;
              if (command_i) begin
                scan_q <= '0;
                best_q <= Nil;
                best_row_q <= '0;
                state_q <= (cnt_q == '0) ? S_DONE : S_P_RD;
                status_q <= (cnt_q == '0) ? StEmpty : StDone;
              end else if ({1'b0, row_i} >= eff_rows) begin
                status_q <= StDropped;
                state_q <= S_DONE;
              end else begin
                status_q <= StDone;
                state_q <= S_A_HEAD;
              end
            end
          end
          S_A_HEAD: begin
            it_q <= head_rd_q;
            prev_q <= Nil;
            ins_prev_q <= Nil;
            ins_at_q <= Nil;
            found_q <= 1'b0;
            state_q <= S_A_RD;
          end
          S_A_RD: begin
            if (it_q >= Nil) begin
              if (!found_q) ins_prev_q <= prev_q;
              step_q <= '0;
              if (free_q >= Nil) begin
                status_q <= StFull;
                state_q <= S_DONE;
              end else begin
                state_q <= S_A_ALLOC;
              end
            end else begin
              state_q <= S_A_CHK;
            end
          end
          S_A_CHK: begin
            if (!found_q && e_rd.f >= req_q.f) begin
              found_q <= 1'b1;
              ins_prev_q <= prev_q;
              ins_at_q <= it_q;
            end
            if (match) begin
              if (!better) begin
                status_q <= StDropped;
                state_q <= S_DONE;
              end else if (found_q ? ins_at_q == it_q : 1'b1) begin
                // found now (f >= req.f holds since better) or found here
                state_q <= S_DONE;
              end else begin
                // relink after ins_prev; head unlink impossible since found earlier
                step_q <= '0;
                state_q <= S_A_LINK;
              end
            end else begin
              prev_q <= it_q;
              it_q <= l_rd;
              state_q <= S_A_RD;
            end
          end
          S_A_ALLOC: begin
            // step 0: write entry, read free.next; step 1: take it
            if (step_q == 2'd0) begin
              step_q <= 2'd1;
            end else begin
              it_q <= free_q;
              free_q <= l_rd;
              cnt_q <= cnt_q + IdxW'(1);
              step_q <= '0;
              state_q <= S_A_LINK;
            end
          end
          S_A_LINK: begin
            step_q <= step_q + 2'd1;
            if (step_q == 2'd2) begin
              state_q <= S_DONE;
            end
          end
          S_P_RD: begin
            if (scan_q == eff_rows) begin
              if (best_q == Nil) begin
                status_q <= StEmpty;
                state_q <= S_DONE;
              end else begin
                step_q <= '0;
                state_q <= S_P_RM;
              end
            end else begin
              state_q <= S_P_HD;
            end
          end
          S_P_HD: begin
            if (head_rd_q >= Nil) begin
              scan_q <= scan_q + 9'd1;
              state_q <= S_P_RD;
            end else begin
              hd_q <= head_rd_q;
              state_q <= S_P_CMP;
            end
          end
          S_P_CMP: begin
            if (best_q == Nil || e_rd.f < best_f_q ||
                (e_rd.f == best_f_q && e_rd.g >= best_g_q)) begin
              best_q <= hd_q;
              best_row_q <= scan_q[RowW-1:0];
              best_f_q <= e_rd.f;
              best_g_q <= e_rd.g;
            end
            scan_q <= scan_q + 9'd1;
            state_q <= S_P_RD;
          end
          S_P_RM: begin
            // step 0: read entry and next; step 1: relink to free list, set row head to next
            if (step_q == 2'd0) begin
              step_q <= 2'd1;
            end else begin
              free_q <= best_q;
              cnt_q <= cnt_q - IdxW'(1);
              out_q <= e_rd;
              state_q <= S_DONE;
            end
          end
          S_DONE: begin
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end
endmodule

// ----- hdl/rbol_entry_ram.sv -----
`timescale 1ns / 1ps
module rbol_entry_ram import rbol_pkg::*; (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Capacity)-1:0] waddr_i,
  input  entry_t                     wdata_i,
  input  logic [$clog2(Capacity)-1:0] raddr_i,
  output entry_t                     rdata_o
);
  entry_t mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hdl/rbol_link_ram.sv -----
`timescale 1ns / 1ps
module rbol_link_ram import rbol_pkg::*; (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Capacity)-1:0] waddr_i,
  input  logic [IdxW-1:0]            wdata_i,
  input  logic [$clog2(Capacity)-1:0] raddr_i,
  output logic [IdxW-1:0]            rdata_o
);
  logic [IdxW-1:0] mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
